[design/mtgd_pkg.sv]
// shared types and constants of the teleinformation group decoder
package mtgd_pkg;

  localparam int TIME_LEN    = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] SEP_OLD    = 7'h20;
  localparam logic [6:0] SEP_STD    = 7'h09;
  localparam logic [6:0] CS_BASE    = 7'h20;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_BAD       = 2'd1;
  localparam logic [1:0] ST_FRAME_OK  = 2'd2;
  localparam logic [1:0] ST_FRAME_BAD = 2'd3;

  localparam logic [2:0] CFG_STANDARD_MODE = 3'd0;
  localparam logic [2:0] CFG_FRAME_START   = 3'd1;
  localparam logic [2:0] CFG_FRAME_END     = 3'd2;
  localparam logic [2:0] CFG_GROUP_START   = 3'd3;
  localparam logic [2:0] CFG_GROUP_END     = 3'd4;

  typedef enum logic [1:0] {
    OP_CONTENT,
    OP_GROUP_START,
    OP_REPORT,
    OP_FRAME_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] ch;
    logic       balanced;
  } entry_t;

  typedef struct packed {
    logic [6:0] frame_start;
    logic [6:0] frame_end;
    logic [6:0] group_start;
    logic [6:0] group_end;
  } codes_t;

endpackage

[design/meter_teleinfo_group_decoder_core.sv]
// top level of the teleinformation group decoder: config registers and the front/queue/back chain
//
// Decodes a meter teleinformation stream one 7-bit character per beat. A character is
// accepted every clock as long as the two-entry queue between the front end (framing and
// group counters) and the back end (field parsing, checksum, value and time decode) has
// room; the back end retires one queued character per clock unless a result waits on a
// full output register, so the sustained rate is one character per cycle. A group end or
// frame end result passes through the queue and then the output register before it appears
// on the out_ channel, and is held in that register; while that register is full
// and not taken, only characters that make a result stall, and once the queue fills
// in_ready drops. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle, a rule for the user that the block itself does not enforce.
module meter_teleinfo_group_decoder_core #(
  parameter int LABEL_CHARS = 9,
  parameter int MAX_GROUPS  = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [62:0] out_label_packed,
  output logic [63:0] out_value_number,
  output logic        out_has_time,
  output logic [6:0]  out_season_char,
  output logic [6:0]  out_year,
  output logic [6:0]  out_month,
  output logic [6:0]  out_day,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second
);
  import mtgd_pkg::*;

  logic   standard_mode_r;
  codes_t codes_r;

  logic   q_ready;
  logic   q_push;
  entry_t push_entry;
  logic   q_valid;
  entry_t head_entry;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      standard_mode_r     <= 1'b0;
      codes_r.frame_start <= 7'd2;
      codes_r.frame_end   <= 7'd3;
      codes_r.group_start <= 7'd10;
      codes_r.group_end   <= 7'd13;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STANDARD_MODE: standard_mode_r     <= cfg_data[0];
        CFG_FRAME_START:   codes_r.frame_start <= cfg_data;
        CFG_FRAME_END:     codes_r.frame_end   <= cfg_data;
        CFG_GROUP_START:   codes_r.group_start <= cfg_data;
        CFG_GROUP_END:     codes_r.group_end   <= cfg_data;
        default: begin
          // unmapped index, write dropped
          standard_mode_r <= standard_mode_r;
        end
      endcase
    end
  end

  mtgd_front #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_char (in_rx_char),
    .codes      (codes_r),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  mtgd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .valid      (q_valid),
    .head_entry (head_entry),
    .pop        (q_pop)
  );

  mtgd_back #(
    .LABEL_CHARS (LABEL_CHARS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .standard_mode    (standard_mode_r),
    .q_valid          (q_valid),
    .q_entry          (head_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_label_packed (out_label_packed),
    .out_value_number (out_value_number),
    .out_has_time     (out_has_time),
    .out_season_char  (out_season_char),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

endmodule

[design/mtgd_front.sv]
// front end: framing state, group counters and character classification
module mtgd_front #(
  parameter int MAX_GROUPS = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [6:0]       in_rx_char,
  input  mtgd_pkg::codes_t codes,
  input  logic             q_ready,
  output logic             q_push,
  output mtgd_pkg::entry_t q_entry
);
  import mtgd_pkg::*;

  localparam int GW = $clog2(MAX_GROUPS + 1);
  localparam logic [GW-1:0] GMAX = GW'(MAX_GROUPS);

  logic          in_frame_r, in_frame_nxt;
  logic          in_group_r, in_group_nxt;
  logic [GW-1:0] opened_r, opened_nxt;
  logic [GW-1:0] closed_r, closed_nxt;
  logic          accept;
  logic          balanced;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign balanced = (opened_r != '0) && (opened_r == closed_r);

  always_comb begin
    in_frame_nxt     = in_frame_r;
    in_group_nxt     = in_group_r;
    opened_nxt       = opened_r;
    closed_nxt       = closed_r;
    q_push           = 1'b0;
    q_entry.op       = OP_CONTENT;
    q_entry.ch       = in_rx_char;
    q_entry.balanced = balanced;
    if (accept) begin
      priority if (in_rx_char == codes.frame_start) begin
        in_frame_nxt = 1'b1;
        in_group_nxt = 1'b0;
        opened_nxt   = '0;
        closed_nxt   = '0;
      end else if (!in_frame_r) begin
        // idle line between frames
        in_frame_nxt = 1'b0;
      end else if (in_rx_char == codes.frame_end) begin
        in_frame_nxt = 1'b0;
        in_group_nxt = 1'b0;
        q_push       = 1'b1;
        q_entry.op   = OP_FRAME_END;
      end else if (in_rx_char == codes.group_start) begin
        if (opened_r < GMAX) opened_nxt = opened_r + 1'b1;
        in_group_nxt = 1'b1;
        q_push       = 1'b1;
        q_entry.op   = OP_GROUP_START;
      end else if (in_rx_char == codes.group_end) begin
        if (closed_r < GMAX) closed_nxt = closed_r + 1'b1;
        if (in_group_r) begin
          in_group_nxt = 1'b0;
          q_push       = 1'b1;
          q_entry.op   = OP_REPORT;
        end
      end else begin
        q_push = in_group_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      in_group_r <= 1'b0;
      opened_r   <= '0;
      closed_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      in_group_r <= in_group_nxt;
      opened_r   <= opened_nxt;
      closed_r   <= closed_nxt;
    end
  end

endmodule

[design/mtgd_queue.sv]
// two-entry queue between the front end and the back end
module mtgd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtgd_pkg::entry_t push_entry,
  output logic             ready,
  output logic             valid,
  output mtgd_pkg::entry_t head_entry,
  input  logic             pop
);
  import mtgd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PLAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(QUEUE_DEPTH);

  entry_t        store_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign ready      = (count_r != CFULL);
  assign valid      = (count_r != '0);
  assign head_entry = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PLAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PLAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_entry;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CFULL)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CFULL)
    else $error("push into full queue");
`endif

endmodule

[design/mtgd_back.sv]
// back end: group field parsing, checksum, value and timestamp decode, result register
module mtgd_back #(
  parameter int LABEL_CHARS = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             standard_mode,
  input  logic             q_valid,
  input  mtgd_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [62:0]      out_label_packed,
  output logic [63:0]      out_value_number,
  output logic             out_has_time,
  output logic [6:0]       out_season_char,
  output logic [6:0]       out_year,
  output logic [6:0]       out_month,
  output logic [6:0]       out_day,
  output logic [6:0]       out_hour,
  output logic [6:0]       out_minute,
  output logic [6:0]       out_second
);
  import mtgd_pkg::*;

  localparam int LW  = 7 * LABEL_CHARS;
  localparam int LCW = $clog2(LABEL_CHARS + 1);
  localparam logic [LCW-1:0] LMAX = LCW'(LABEL_CHARS);
  localparam logic [3:0] TLEN = 4'(TIME_LEN);

  // group state
  logic [2:0]     seps_r;
  logic [5:0]     sum_tv_r;
  logic [5:0]     sum_time_r;
  logic [6:0]     cap2_r;
  logic [6:0]     cap3_r;
  logic           pend2_r;
  logic           pend3_r;
  logic [LW-1:0]  label_r;
  logic [LCW-1:0] label_count_r;
  logic [63:0]    value_acc_r;
  logic           value_done_r;
  logic [63:0]    third_acc_r;
  logic           third_done_r;
  logic [3:0]     tlen_r;
  logic [6:0]     time_chars_r [TIME_LEN];

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r;
  logic [62:0] label_out_r;
  logic [63:0] value_out_r;
  logic        has_time_r;
  logic [6:0]  season_r, year_r, month_r, day_r, hour_r, minute_r, second_r;

  logic        is_result;
  logic        do_pop;
  logic [6:0]  c;
  logic [6:0]  sep;
  logic        is_sep;
  logic        is_digit;
  logic [63:0] dig_acc_in;
  logic [67:0] dig_wide;
  logic [63:0] dig_acc_out;
  logic        tc_we;
  logic        good;
  logic        timed;
  logic        std3;
  logic [5:0]  label_shamt;
  logic [LW-1:0] label_aligned;
  logic [5:0]  sum_std2;
  logic [5:0]  sum_std3;

  function automatic logic [6:0] two_digits(input logic [6:0] a, input logic [6:0] b);
    return 7'(a[3:0]) * 7'd10 + 7'(b[3:0]);
  endfunction

  assign c         = q_entry.ch;
  assign sep       = standard_mode ? SEP_STD : SEP_OLD;
  assign is_sep    = (c == sep);
  assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_result = (q_entry.op == OP_REPORT) || (q_entry.op == OP_FRAME_END);
  assign q_pop     = q_valid && (!is_result || !out_valid_r || out_ready);
  assign do_pop    = q_pop;

  // shared decimal step, saturating: acc*10 + d
  assign dig_acc_in  = (seps_r == 3'd2) ? third_acc_r : value_acc_r;
  assign dig_wide    = {1'b0, dig_acc_in, 3'b0} + {3'b0, dig_acc_in, 1'b0} + 68'(c[3:0]);
  assign dig_acc_out = (dig_wide[67:64] != 4'b0) ? '1 : dig_wide[63:0];

  assign tc_we = do_pop && (q_entry.op == OP_CONTENT) && !is_sep && (seps_r == 3'd1)
               && (tlen_r < TLEN);

  // group verdict
  assign std3     = standard_mode && (seps_r == 3'd3);
  assign sum_std2 = sum_tv_r + SEP_STD[5:0];
  assign sum_std3 = sum_tv_r + sum_time_r;

  always_comb begin
    good = 1'b0;
    if (!standard_mode) begin
      good = (seps_r >= 3'd2) && (cap2_r == {1'b0, sum_tv_r} + CS_BASE);
    end else if (seps_r == 3'd2) begin
      good = (cap2_r == {1'b0, sum_std2} + CS_BASE);
    end else if (seps_r == 3'd3) begin
      good = (cap3_r == {1'b0, sum_std3} + CS_BASE);
    end
  end

  always_comb begin
    timed = std3 && (tlen_r == TLEN);
    for (int i = 1; i < TIME_LEN; i++) begin
      if ((time_chars_r[i] < CHAR_ZERO) || (time_chars_r[i] > CHAR_NINE)) timed = 1'b0;
    end
  end

  assign label_shamt   = 6'((LABEL_CHARS - int'(label_count_r)) * 7);
  assign label_aligned = label_r << label_shamt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_pop && is_result) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && is_result) begin
      if (q_entry.op == OP_FRAME_END) begin
        status_r    <= q_entry.balanced ? ST_FRAME_OK : ST_FRAME_BAD;
        label_out_r <= '0;
        value_out_r <= '0;
      end else begin
        status_r    <= good ? ST_GOOD : ST_BAD;
        label_out_r <= 63'(label_aligned);
        value_out_r <= std3 ? third_acc_r : value_acc_r;
      end
      if ((q_entry.op == OP_REPORT) && timed) begin
        has_time_r <= 1'b1;
        season_r   <= time_chars_r[0];
        year_r     <= two_digits(time_chars_r[1],  time_chars_r[2]);
        month_r    <= two_digits(time_chars_r[3],  time_chars_r[4]);
        day_r      <= two_digits(time_chars_r[5],  time_chars_r[6]);
        hour_r     <= two_digits(time_chars_r[7],  time_chars_r[8]);
        minute_r   <= two_digits(time_chars_r[9],  time_chars_r[10]);
        second_r   <= two_digits(time_chars_r[11], time_chars_r[12]);
      end else begin
        has_time_r <= 1'b0;
        season_r   <= '0;
        year_r     <= '0;
        month_r    <= '0;
        day_r      <= '0;
        hour_r     <= '0;
        minute_r   <= '0;
        second_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seps_r        <= '0;
      sum_tv_r      <= '0;
      sum_time_r    <= '0;
      cap2_r        <= '0;
      cap3_r        <= '0;
      pend2_r       <= 1'b0;
      pend3_r       <= 1'b0;
      label_r       <= '0;
      label_count_r <= '0;
      value_acc_r   <= '0;
      value_done_r  <= 1'b0;
      third_acc_r   <= '0;
      third_done_r  <= 1'b0;
      tlen_r        <= '0;
    end else if (do_pop && (q_entry.op == OP_GROUP_START)) begin
      seps_r        <= '0;
      sum_tv_r      <= '0;
      sum_time_r    <= '0;
      cap2_r        <= '0;
      cap3_r        <= '0;
      pend2_r       <= 1'b0;
      pend3_r       <= 1'b0;
      label_r       <= '0;
      label_count_r <= '0;
      value_acc_r   <= '0;
      value_done_r  <= 1'b0;
      third_acc_r   <= '0;
      third_done_r  <= 1'b0;
      tlen_r        <= '0;
    end else if (do_pop && (q_entry.op == OP_CONTENT)) begin
      // checksum character is the one right after the separator
      if (pend2_r) cap2_r <= c;
      else if (pend3_r) cap3_r <= c;
      pend2_r <= 1'b0;
      pend3_r <= 1'b0;
      if (is_sep) begin
        if (seps_r == 3'd0) sum_tv_r <= sum_tv_r + c[5:0];
        else if ((seps_r == 3'd1) || (seps_r == 3'd2)) sum_time_r <= sum_time_r + c[5:0];
        if (seps_r != 3'd7) seps_r <= seps_r + 1'b1;
        pend2_r <= (seps_r == 3'd1);
        pend3_r <= (seps_r == 3'd2);
      end else begin
        unique case (seps_r)
          3'd0: begin
            sum_tv_r <= sum_tv_r + c[5:0];
            if (label_count_r < LMAX) begin
              label_r       <= (label_r << 7) | LW'(c);
              label_count_r <= label_count_r + 1'b1;
            end
          end
          3'd1: begin
            sum_tv_r <= sum_tv_r + c[5:0];
            if (!value_done_r) begin
              if (is_digit) value_acc_r <= dig_acc_out;
              else value_done_r <= 1'b1;
            end
            if (tlen_r <= TLEN) tlen_r <= tlen_r + 1'b1;
          end
          3'd2: begin
            sum_time_r <= sum_time_r + c[5:0];
            if (!third_done_r) begin
              if (is_digit) third_acc_r <= dig_acc_out;
              else third_done_r <= 1'b1;
            end
          end
          default: begin
            // trailing fields carry nothing
            third_done_r <= third_done_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tc_we) time_chars_r[tlen_r] <= c;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_label_packed = label_out_r;
  assign out_value_number = value_out_r;
  assign out_has_time     = has_time_r;
  assign out_season_char  = season_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day          = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;

`ifndef ASSERT_OFF
  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_FRAME_OK) || (out_status == ST_FRAME_BAD))
      |-> (out_label_packed == '0) && (out_value_number == '0) && !out_has_time)
    else $error("frame end beat carries group fields");
  a_no_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_time
      |-> (out_season_char == '0) && (out_year == '0) && (out_month == '0)
          && (out_day == '0) && (out_hour == '0) && (out_minute == '0)
          && (out_second == '0))
    else $error("time fields set without a timestamp");
  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && is_result && out_valid_r |-> out_ready)
    else $error("result register overwritten before taken");
`endif

endmodule

[sim/tb_meter_teleinfo_group_decoder_core.sv]
// testbench of the teleinformation group decoder: random meter frames checked against a predictor
module tb_meter_teleinfo_group_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mtgd_pkg::*;

  localparam int LABEL_N     = 9;
  localparam int MAX_GRP     = 255;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [6:0] DEF_FRAME_START = 7'd2;
  localparam logic [6:0] DEF_FRAME_END   = 7'd3;
  localparam logic [6:0] DEF_GROUP_START = 7'd10;
  localparam logic [6:0] DEF_GROUP_END   = 7'd13;
  localparam logic [6:0] CH_WINTER       = 7'h48;
  localparam logic [6:0] CH_SUMMER       = 7'h45;

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] label;
    logic [63:0] value;
    logic        has_time;
    logic [6:0]  season;
    logic [6:0]  year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } report_t;

  // tracks frame and group decoding and holds the reports still owed by the block
  class group_report_book;
    bit          std_mode;
    bit [6:0]    fs_code, fe_code, gs_code, ge_code;
    bit          in_frame, in_group;
    int unsigned seps;
    bit [5:0]    sum_lv, sum_tm;
    bit [6:0]    after_sep2, after_sep3;
    bit [62:0]   label_sh;
    int unsigned label_cnt;
    bit [63:0]   value_acc, third_acc;
    bit          value_stop, third_stop;
    bit [6:0]    time_buf [TIME_LEN];
    int unsigned time_cnt;
    int unsigned opened, closed;
    int unsigned capture;
    report_t     reports_due[$];
    int unsigned mismatches;

    function new();
      fs_code = DEF_FRAME_START;
      fe_code = DEF_FRAME_END;
      gs_code = DEF_GROUP_START;
      ge_code = DEF_GROUP_END;
      foreach (time_buf[i]) time_buf[i] = '0;
      clear_group();
    endfunction

    function void clear_group();
      seps = 0;
      sum_lv = '0;
      sum_tm = '0;
      after_sep2 = '0;
      after_sep3 = '0;
      label_sh = '0;
      label_cnt = 0;
      value_acc = '0;
      value_stop = 1'b0;
      time_cnt = 0;
      capture = 0;
      third_acc = '0;
      third_stop = 1'b0;
    endfunction

    function bit is_digit(bit [6:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // one more decimal digit, pinned at all ones on overflow
    function bit [63:0] dec_step(bit [63:0] acc, bit [6:0] c);
      bit [63:0] d;
      d = c - CHAR_ZERO;
      if (acc > (~64'd0 - d) / 10) return ~64'd0;
      return acc * 10 + d;
    endfunction

    function void field_char(bit [6:0] c);
      bit [6:0]    sep;
      int unsigned n;
      sep = std_mode ? SEP_STD : SEP_OLD;
      n = seps;
      if (capture == 2) after_sep2 = c;
      else if (capture == 3) after_sep3 = c;
      capture = 0;
      if (c == sep) begin
        if (n == 0) sum_lv = sum_lv + c[5:0];
        else if (n == 1 || n == 2) sum_tm = sum_tm + c[5:0];
        if (n < 7) seps = n + 1;
        if ((seps == 2 || seps == 3) && seps == n + 1) capture = seps;
        return;
      end
      if (n == 0) begin
        sum_lv = sum_lv + c[5:0];
        if (label_cnt < LABEL_N) begin
          label_sh = {label_sh[55:0], c};
          label_cnt++;
        end
      end else if (n == 1) begin
        sum_lv = sum_lv + c[5:0];
        if (!value_stop) begin
          if (is_digit(c)) value_acc = dec_step(value_acc, c);
          else value_stop = 1'b1;
        end
        if (time_cnt < TIME_LEN) time_buf[time_cnt] = c;
        if (time_cnt <= TIME_LEN) time_cnt++;
      end else if (n == 2) begin
        sum_tm = sum_tm + c[5:0];
        if (!third_stop) begin
          if (is_digit(c)) third_acc = dec_step(third_acc, c);
          else third_stop = 1'b1;
        end
      end
    endfunction

    function bit [6:0] two_digits(int i);
      return 7'((time_buf[i] - CHAR_ZERO) * 10 + (time_buf[i + 1] - CHAR_ZERO));
    endfunction

    function report_t group_report();
      report_t r;
      bit      good, timed;
      bit [5:0] s;
      int      i;
      r = '0;
      good = 1'b0;
      timed = 1'b0;
      if (!std_mode) begin
        if (seps >= 2) good = after_sep2 == {1'b0, sum_lv} + CS_BASE;
      end else if (seps == 2) begin
        s = sum_lv + SEP_STD[5:0];
        good = after_sep2 == {1'b0, s} + CS_BASE;
      end else if (seps == 3) begin
        s = sum_lv + sum_tm;
        good = after_sep3 == {1'b0, s} + CS_BASE;
      end
      r.status = good ? ST_GOOD : ST_BAD;
      r.label  = label_sh << (7 * (LABEL_N - label_cnt));
      r.value  = (std_mode && seps == 3) ? third_acc : value_acc;
      if (std_mode && seps == 3 && time_cnt == TIME_LEN) begin
        timed = 1'b1;
        for (i = 1; i < TIME_LEN; i++)
          if (!is_digit(time_buf[i])) timed = 1'b0;
      end
      if (timed) begin
        r.has_time = 1'b1;
        r.season   = time_buf[0];
        r.year     = two_digits(1);
        r.month    = two_digits(3);
        r.day      = two_digits(5);
        r.hour     = two_digits(7);
        r.minute   = two_digits(9);
        r.second   = two_digits(11);
      end
      return r;
    endfunction

    // called for every accepted input beat
    function void take_char(bit [6:0] c);
      report_t r;
      r = '0;
      if (c == fs_code) begin
        in_frame = 1'b1;
        in_group = 1'b0;
        opened = 0;
        closed = 0;
        return;
      end
      if (!in_frame) return;
      if (c == fe_code) begin
        r.status = (opened != 0 && opened == closed) ? ST_FRAME_OK : ST_FRAME_BAD;
        in_frame = 1'b0;
        in_group = 1'b0;
        reports_due.push_back(r);
        return;
      end
      if (c == gs_code) begin
        if (opened < MAX_GRP) opened++;
        in_group = 1'b1;
        clear_group();
        return;
      end
      if (c == ge_code) begin
        if (closed < MAX_GRP) closed++;
        if (!in_group) return;
        in_group = 1'b0;
        reports_due.push_back(group_report());
        return;
      end
      if (in_group) field_char(c);
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", what, want, got);
        mismatches++;
      end
    endfunction

    // called for every accepted output beat
    function void check_report(report_t got);
      report_t want;
      if (reports_due.size() == 0) begin
        $error("result beat with none expected, status %0d", got.status);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      compare("status", want.status, got.status);
      compare("label_packed", want.label, got.label);
      compare("value_number", want.value, got.value);
      compare("has_time", want.has_time, got.has_time);
      compare("season_char", want.season, got.season);
      compare("year", want.year, got.year);
      compare("month", want.month, got.month);
      compare("day", want.day, got.day);
      compare("hour", want.hour, got.hour);
      compare("minute", want.minute, got.minute);
      compare("second", want.second, got.second);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [6:0]  in_rx_char = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [62:0] out_label_packed;
  logic [63:0] out_value_number;
  logic        out_has_time;
  logic [6:0]  out_season_char, out_year, out_month, out_day;
  logic [6:0]  out_hour, out_minute, out_second;
  report_t     dut_report;

  group_report_book book;
  int          burst_left = 0;
  int          beats_sent = 0;
  int          rx_mode = 0;
  int          rx_tick = 0;
  int unsigned cycle_cnt = 0;
  bit [6:0]    line_q[$];
  bit [5:0]    line_sum;

  meter_teleinfo_group_decoder_core #(
    .LABEL_CHARS(LABEL_N),
    .MAX_GROUPS (MAX_GRP)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_char      (in_rx_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_label_packed(out_label_packed),
    .out_value_number(out_value_number),
    .out_has_time    (out_has_time),
    .out_season_char (out_season_char),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second)
  );

  assign dut_report = {out_status, out_label_packed, out_value_number, out_has_time,
                       out_season_char, out_year, out_month, out_day, out_hour,
                       out_minute, out_second};

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: switches out_ready between random stall styles
  always @(posedge clk) begin
    if (rx_tick == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_tick = $urandom_range(20, 120);
    end
    rx_tick--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_tick % 9) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_report(dut_report);
  end

  task automatic send_char(input bit [6:0] c);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.take_char(c);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(7'(s[i]));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (book.reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STANDARD_MODE: book.std_mode = data[0];
      CFG_FRAME_START:   book.fs_code = data;
      CFG_FRAME_END:     book.fe_code = data;
      CFG_GROUP_START:   book.gs_code = data;
      CFG_GROUP_END:     book.ge_code = data;
      default: ;
    endcase
  endtask

  // upper data bits are noise, only bit 0 selects the mode
  task automatic set_mode(input bit std);
    write_reg(CFG_STANDARD_MODE, {6'($urandom_range(0, 63)), std});
  endtask

  task automatic set_codes(input bit [6:0] fs, input bit [6:0] fe,
                           input bit [6:0] gs, input bit [6:0] ge);
    write_reg(CFG_FRAME_START, fs);
    write_reg(CFG_FRAME_END, fe);
    write_reg(CFG_GROUP_START, gs);
    write_reg(CFG_GROUP_END, ge);
  endtask

  function automatic bit [6:0] label_char();
    if ($urandom_range(0, 3) == 0) return CHAR_ZERO + 7'($urandom_range(0, 9));
    return 7'($urandom_range(65, 90));
  endfunction

  function automatic void put(bit [6:0] c);
    line_q.push_back(c);
    line_sum = line_sum + c[5:0];
  endfunction

  // one group body in the current mode, mostly well formed
  function automatic void build_group();
    bit [6:0] sep, cs;
    int       lab_len, val_len, tlen, bad_pos, i;
    bit       all_nine;
    sep = book.std_mode ? SEP_STD : SEP_OLD;
    line_q.delete();
    line_sum = '0;
    lab_len = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 9);
    for (i = 0; i < lab_len; i++) put(label_char());
    put(sep);
    if (book.std_mode && $urandom_range(0, 2) != 0) begin
      tlen = 13;
      if ($urandom_range(0, 7) == 0) tlen = $urandom_range(0, 1) ? 12 : 14;
      bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(1, tlen - 1) : 0;
      case ($urandom_range(0, 4))
        0, 1: put(CH_WINTER);
        2, 3: put(CH_SUMMER);
        default: put(7'($urandom_range(33, 125)));
      endcase
      for (i = 1; i < tlen; i++)
        put(i == bad_pos ? 7'($urandom_range(65, 90)) : CHAR_ZERO + 7'($urandom_range(0, 9)));
      put(sep);
    end
    case ($urandom_range(0, 9))
      0: val_len = 0;
      1: val_len = $urandom_range(19, 24);
      default: val_len = $urandom_range(1, 10);
    endcase
    all_nine = ($urandom_range(0, 3) == 0);
    for (i = 0; i < val_len; i++)
      put(all_nine ? CHAR_NINE : CHAR_ZERO + 7'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) put(7'($urandom_range(65, 90)));
    // older mode sums stop before the second separator, standard mode includes it
    if (!book.std_mode) cs = {1'b0, line_sum} + CS_BASE;
    put(sep);
    if (book.std_mode) cs = {1'b0, line_sum} + CS_BASE;
    case ($urandom_range(0, 11))
      0: line_q.push_back(cs ^ 7'($urandom_range(1, 63)));
      1: ;
      2: begin
        line_q.push_back(cs);
        line_q.insert($urandom_range(1, line_q.size() - 1), sep);
      end
      3: begin
        line_q.push_back(cs);
        line_q.delete(lab_len);
      end
      default: line_q.push_back(cs);
    endcase
  endfunction

  task automatic send_frame();
    int groups, i, j;
    send_char(book.fs_code);
    groups = $urandom_range(0, 5);
    for (i = 0; i < groups; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(7'($urandom_range(0, 127)));
      send_char(book.gs_code);
      build_group();
      if ($urandom_range(0, 15) == 0) begin
        // drop the group half way, sometimes by restarting the whole frame
        for (j = 0; j < line_q.size() / 2; j++) send_char(line_q[j]);
        if ($urandom_range(0, 1)) send_char(book.fs_code);
        send_char(book.gs_code);
        build_group();
      end
      foreach (line_q[j]) send_char(line_q[j]);
      if ($urandom_range(0, 11) != 0) send_char(book.ge_code);
      if ($urandom_range(0, 15) == 0) send_char(book.ge_code);
    end
    case ($urandom_range(0, 11))
      0: ;
      1: begin
        send_char(book.fs_code);
        send_char(book.fe_code);
      end
      default: send_char(book.fe_code);
    endcase
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) send_char(7'($urandom_range(0, 127)));
  endtask

  task automatic run_random(input int n);
    int first;
    first = beats_sent;
    while (beats_sent - first < n) send_frame();
  endtask

  // more openings than closings, but both counters pin at the maximum
  task automatic send_saturating_frame();
    send_char(book.fs_code);
    repeat (MAX_GRP + 3) send_char(book.gs_code);
    repeat (MAX_GRP + 1) send_char(book.ge_code);
    send_char(book.fe_code);
  endtask

  function automatic bit [6:0] pick_code();
    case ($urandom_range(0, 3))
      0: return DEF_FRAME_START;
      1: return DEF_FRAME_END;
      2: return DEF_GROUP_START;
      default: return DEF_GROUP_END;
    endcase
  endfunction

  initial begin
    book = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // older mode with reset codes: ignored bytes, empty frame, stray close, restarts
    send_char(7'h7F);
    send_char(7'h00);
    send_char(book.fe_code);
    send_char(book.fs_code);
    send_char(book.fe_code);
    send_char(book.fs_code);
    send_char(book.ge_code);
    send_char(book.gs_code);
    send_text("A 1 2");
    send_char(book.ge_code);
    send_char(book.fe_code);
    send_char(book.fs_code);
    send_char(book.gs_code);
    send_char(book.gs_code);
    send_char(book.ge_code);
    send_char(book.fs_code);
    send_char(book.gs_code);
    send_text("B");
    send_char(book.fs_code);
    send_char(book.fe_code);
    run_random(60);
    wait_idle();

    set_mode(1'b1);
    set_codes(DEF_FRAME_START, DEF_FRAME_END, DEF_GROUP_START, DEF_GROUP_END);
    send_saturating_frame();
    run_random(80);
    wait_idle();

    set_codes(7'd0, 7'd127, 7'd1, 7'd126);
    run_random(40);
    wait_idle();

    set_mode(1'b0);
    set_codes(7'd127, 7'd0, 7'd126, 7'd1);
    run_random(40);
    wait_idle();

    // group codes may collide with the frame codes or with each other
    set_mode(1'($urandom_range(0, 1)));
    set_codes(DEF_FRAME_START, DEF_FRAME_END, pick_code(), pick_code());
    run_random(30);
    wait_idle();
    repeat (12) @(posedge clk);

    if (book.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
